// ----- design/sus_pkg.sv -----
package sus_pkg;

  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;
  localparam int PORT_KEY_W = 32;

  localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SHIFT    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_DECIDE,
    S_TAKE,
    S_TGET,
    S_DROP,
    S_DMOV,
    S_INS,
    S_IMOV,
    S_RDMIN,
    S_RDMAX,
    S_GETMAX,
    S_OUT
  } state_t;

endpackage

// ----- design/sorted_unique_key_set_unit.sv -----
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  command, key
// output   out        out_valid / out_stall status, hit, taken_key, count, smallest, largest
//
// An item runs to completion before the next is taken. Clear, and pop and shift on an empty set,
// take the shortest path, and remove of the smallest key from a full set the longest: each binary
// search step (S_SRCH, S_CMP) and each moved entry (S_DROP, S_DMOV or S_INS, S_IMOV) goes through
// the one read and one write port.
// in_stall is high from the transfer of an item until its result is loaded into the
// output register; that register holds while out_stall is high.
// Reset (rst, synchronous) empties the set; the key store itself is not cleared.
module sorted_unique_key_set_unit #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sus_pkg::CMD_W-1:0]       command,
  input  logic [sus_pkg::PORT_KEY_W-1:0]  key,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sus_pkg::STATUS_W-1:0]    status,
  output logic                            hit,
  output logic [sus_pkg::PORT_KEY_W-1:0]  taken_key,
  output logic [sus_pkg::COUNT_W-1:0]     count,
  output logic [sus_pkg::PORT_KEY_W-1:0]  smallest,
  output logic [sus_pkg::PORT_KEY_W-1:0]  largest
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int KW    = KEY_BITS;
  localparam int PKW   = sus_pkg::PORT_KEY_W;
  localparam int CNT_W = sus_pkg::COUNT_W;

  sus_pkg::state_t state, state_next;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [KW-1:0]              mem_wdata;
  logic [AW-1:0]              mem_raddr;
  logic [KW-1:0]              mem_rdata;

  logic [sus_pkg::CMD_W-1:0]  cmd_r;
  logic [KW-1:0]              key_r;
  logic [CW-1:0]              lo, hi, mid, pos, idx;
  logic                       found;
  logic [sus_pkg::STATUS_W-1:0] status_r;
  logic                       hit_r;
  logic [KW-1:0]              taken_r, smallest_r, largest_r;
  logic [CW-1:0]              held_count;

  logic [CW-1:0]              mid_calc, count_m1, idx_p1, idx_m1;
  logic                       accept, out_load, is_full, key_eq, key_lt;

  assign in_stall = (state != sus_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == sus_pkg::S_OUT) && (!out_valid || !out_stall);

  assign mid_calc = lo + ((hi - lo) >> 1);
  assign count_m1 = held_count - 1'b1;
  assign idx_p1   = idx + 1'b1;
  assign idx_m1   = idx - 1'b1;
  assign is_full  = (held_count >= CW'(DEPTH));

  // The one compare unit, fed by the store's read data.
  assign key_eq = (key_r == mem_rdata);
  assign key_lt = (key_r < mem_rdata);

  sus_mem #(
    .DEPTH(DEPTH),
    .WIDTH(KW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sus_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = key_r;
    mem_raddr  = '0;
    unique case (state)
      sus_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (command) inside
            sus_pkg::CMD_ADD, sus_pkg::CMD_REMOVE, sus_pkg::CMD_CONTAINS: begin
              state_next = sus_pkg::S_SRCH;
            end
            sus_pkg::CMD_POP, sus_pkg::CMD_SHIFT: begin
              state_next = (held_count == '0) ? sus_pkg::S_RDMIN : sus_pkg::S_TAKE;
            end
            default: begin
              state_next = sus_pkg::S_RDMIN;
            end
          endcase
        end
      end
      sus_pkg::S_SRCH: begin
        if (lo < hi) begin
          mem_raddr  = mid_calc[AW-1:0];
          state_next = sus_pkg::S_CMP;
        end else begin
          state_next = sus_pkg::S_DECIDE;
        end
      end
      sus_pkg::S_CMP: begin
        state_next = key_eq ? sus_pkg::S_DECIDE : sus_pkg::S_SRCH;
      end
      sus_pkg::S_DECIDE: begin
        if (cmd_r == sus_pkg::CMD_REMOVE && found) begin
          state_next = sus_pkg::S_DROP;
        end else if (cmd_r == sus_pkg::CMD_ADD && !found && !is_full) begin
          state_next = sus_pkg::S_INS;
        end else begin
          state_next = sus_pkg::S_RDMIN;
        end
      end
      sus_pkg::S_TAKE: begin
        mem_raddr  = (cmd_r == sus_pkg::CMD_POP) ? count_m1[AW-1:0] : '0;
        state_next = sus_pkg::S_TGET;
      end
      sus_pkg::S_TGET: begin
        state_next = (cmd_r == sus_pkg::CMD_SHIFT) ? sus_pkg::S_DROP : sus_pkg::S_RDMIN;
      end
      sus_pkg::S_DROP: begin
        if (idx_p1 < held_count) begin
          mem_raddr  = idx_p1[AW-1:0];
          state_next = sus_pkg::S_DMOV;
        end else begin
          state_next = sus_pkg::S_RDMIN;
        end
      end
      sus_pkg::S_DMOV: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[AW-1:0];
        mem_wdata  = mem_rdata;
        state_next = sus_pkg::S_DROP;
      end
      sus_pkg::S_INS: begin
        if (idx > pos) begin
          mem_raddr  = idx_m1[AW-1:0];
          state_next = sus_pkg::S_IMOV;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = pos[AW-1:0];
          mem_wdata  = key_r;
          state_next = sus_pkg::S_RDMIN;
        end
      end
      sus_pkg::S_IMOV: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[AW-1:0];
        mem_wdata  = mem_rdata;
        state_next = sus_pkg::S_INS;
      end
      sus_pkg::S_RDMIN: begin
        if (held_count == '0) begin
          state_next = sus_pkg::S_OUT;
        end else begin
          state_next = sus_pkg::S_RDMAX;
        end
      end
      sus_pkg::S_RDMAX: begin
        mem_raddr  = count_m1[AW-1:0];
        state_next = sus_pkg::S_GETMAX;
      end
      sus_pkg::S_GETMAX: begin
        state_next = sus_pkg::S_OUT;
      end
      sus_pkg::S_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = sus_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sus_pkg::S_IDLE;
      end
    endcase
  end

  // Count and output valid are, with the sequencer state, the only registers that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept && command == sus_pkg::CMD_CLEAR) begin
        held_count <= '0;
      end else if (state == sus_pkg::S_TGET && cmd_r == sus_pkg::CMD_POP) begin
        held_count <= count_m1;
      end else if (state == sus_pkg::S_DROP && !(idx_p1 < held_count)) begin
        held_count <= count_m1;
      end else if (state == sus_pkg::S_INS && !(idx > pos)) begin
        held_count <= held_count + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sus_pkg::S_IDLE: begin
        if (accept) begin
          cmd_r    <= command;
          key_r    <= KW'(key);
          lo       <= '0;
          hi       <= held_count;
          idx      <= '0;
          found    <= 1'b0;
          status_r <= sus_pkg::ST_OK;
          hit_r    <= 1'b0;
          taken_r  <= '0;
          if (command == sus_pkg::CMD_CLEAR) begin
            hit_r <= (held_count != '0);
          end
          if ((command == sus_pkg::CMD_POP || command == sus_pkg::CMD_SHIFT)
              && held_count == '0) begin
            status_r <= sus_pkg::ST_UNDERFLOW;
          end
        end
      end
      sus_pkg::S_SRCH: begin
        if (lo < hi) begin
          mid <= mid_calc;
        end else begin
          pos <= lo;
        end
      end
      sus_pkg::S_CMP: begin
        if (key_eq) begin
          found <= 1'b1;
          pos   <= mid;
        end else if (key_lt) begin
          hi <= mid;
        end else begin
          lo <= mid + 1'b1;
        end
      end
      sus_pkg::S_DECIDE: begin
        if (cmd_r == sus_pkg::CMD_CONTAINS) begin
          hit_r <= found;
        end else if (cmd_r == sus_pkg::CMD_REMOVE && found) begin
          idx   <= pos;
          hit_r <= 1'b1;
        end else if (cmd_r == sus_pkg::CMD_ADD && !found) begin
          if (is_full) begin
            status_r <= sus_pkg::ST_FULL;
          end else begin
            idx   <= held_count;
            hit_r <= 1'b1;
          end
        end
      end
      sus_pkg::S_TGET: begin
        taken_r <= mem_rdata;
        hit_r   <= 1'b1;
      end
      sus_pkg::S_DMOV: begin
        idx <= idx_p1;
      end
      sus_pkg::S_IMOV: begin
        idx <= idx_m1;
      end
      sus_pkg::S_RDMIN: begin
        if (held_count == '0) begin
          smallest_r <= '0;
          largest_r  <= '0;
        end
      end
      sus_pkg::S_RDMAX: begin
        smallest_r <= mem_rdata;
      end
      sus_pkg::S_GETMAX: begin
        largest_r <= mem_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status    <= status_r;
      hit       <= hit_r;
      taken_key <= PKW'(taken_r);
      count     <= CNT_W'(held_count);
      smallest  <= PKW'(smallest_r);
      largest   <= PKW'(largest_r);
    end
  end

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("block took a transfer but did not go busy");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(DEPTH))
    else $error("held count exceeds capacity");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && (state == sus_pkg::S_IDLE))
    else $error("result not presented after load");

  a_order_kept: assert property (@(posedge clk) disable iff (rst)
    (state == sus_pkg::S_OUT) && (held_count != '0) |-> (smallest_r <= largest_r))
    else $error("smallest key above largest key");
`endif

endmodule

// ----- design/sus_mem.sv -----
module sus_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
